>>> rtl/hsc_pkg.sv
// shared types and elaboration-time helpers for the hamming row codec
package hsc_pkg;

	// status flags of one decoded row
	typedef struct packed {
		logic corrected;
		logic uncorrectable;
	} hsc_flags_t;

	// operating mode of a beat
	typedef enum logic {
		MODE_ENCODE = 1'b0,
		MODE_DECODE = 1'b1
	} hsc_mode_t;

	// least r with 2^r >= m + r + 1
	function automatic int parity_count(input int m);
		int r;
		r = 0;
		while ((1 << r) < (m + r + 1)) begin
			r++;
		end
		return r;
	endfunction

	// codeword length for a row of b bytes
	function automatic int row_len(input int b);
		return 8 * b + parity_count(8 * b);
	endfunction

	// true for parity positions
	function automatic bit is_pow2(input int j);
		return (j != 0) && ((j & (j - 1)) == 0);
	endfunction

	// zero-based order of the data bit held at non-parity position j
	function automatic int data_index(input int j);
		return j - $clog2(j + 1) - 1;
	endfunction

endpackage

>>> rtl/hsc_scatter.sv
// stage one logic: place row data on codeword positions, or mask the received word
module hsc_scatter #(
	parameter int MAX_ROW_BYTES = 4,
	localparam int DATA_W = 8 * MAX_ROW_BYTES,
	localparam int R_W = hsc_pkg::parity_count(DATA_W),
	localparam int CW_W = DATA_W + R_W,
	localparam int NB_W = $clog2(MAX_ROW_BYTES + 1)
) (
	input  hsc_pkg::hsc_mode_t mode,
	input  logic [NB_W-1:0]    nb,
	input  logic [DATA_W-1:0]  data_in,
	input  logic [CW_W-1:0]    codeword_in,
	output logic [CW_W-1:0]    pw
);
	import hsc_pkg::*;

	logic [CW_W-1:0] scat;
	logic [CW_W-1:0] len_mask;

	// data bits go to the non-parity positions, first data bit first
	always_comb begin
		int idx;
		idx = 0;
		scat = '0;
		len_mask = '0;
		for (int b = 1; b <= MAX_ROW_BYTES; b++) begin
			if (nb == NB_W'(b)) begin
				for (int j = 1; j <= CW_W; j++) begin
					if (j <= row_len(b)) begin
						len_mask[j-1] = 1'b1;
						if (!is_pow2(j)) begin
							idx = 8 * b - 1 - data_index(j);
							if (idx >= 0) begin
								scat[j-1] = data_in[idx];
							end
						end
					end
				end
			end
		end
	end

	// decode keeps only positions inside the row
	assign pw = (mode == MODE_DECODE) ? (codeword_in & len_mask) : scat;

endmodule

>>> rtl/hsc_syndrome.sv
// stage two logic: xor of the positions that hold a one
module hsc_syndrome #(
	parameter int MAX_ROW_BYTES = 4,
	localparam int DATA_W = 8 * MAX_ROW_BYTES,
	localparam int R_W = hsc_pkg::parity_count(DATA_W),
	localparam int CW_W = DATA_W + R_W
) (
	input  logic [CW_W-1:0] pw,
	output logic [R_W-1:0]  syn
);
	import hsc_pkg::*;

	// independent xor per syndrome bit, folded by synthesis into trees
	always_comb begin
		syn = '0;
		for (int j = 1; j <= CW_W; j++) begin
			if (pw[j-1]) begin
				syn = syn ^ R_W'(j);
			end
		end
	end

endmodule

>>> rtl/hsc_finish.sv
// stage three logic: set parity on encode, correct and extract on decode
module hsc_finish #(
	parameter int MAX_ROW_BYTES = 4,
	localparam int DATA_W = 8 * MAX_ROW_BYTES,
	localparam int R_W = hsc_pkg::parity_count(DATA_W),
	localparam int CW_W = DATA_W + R_W,
	localparam int NB_W = $clog2(MAX_ROW_BYTES + 1)
) (
	input  hsc_pkg::hsc_mode_t  mode,
	input  logic [NB_W-1:0]     nb,
	input  logic [CW_W-1:0]     pw,
	input  logic [R_W-1:0]      syn,
	output logic [CW_W-1:0]     codeword_out,
	output logic [DATA_W-1:0]   data_out,
	output logic [R_W-1:0]      syndrome,
	output hsc_pkg::hsc_flags_t flags
);
	import hsc_pkg::*;

	logic [R_W-1:0]    n_sel;
	logic [CW_W-1:0]   cw_fix;
	logic [CW_W-1:0]   enc;
	logic [DATA_W-1:0] ext;
	hsc_flags_t        dec_flags;

	// codeword length for the configured row
	always_comb begin
		n_sel = '0;
		for (int b = 1; b <= MAX_ROW_BYTES; b++) begin
			if (nb == NB_W'(b)) begin
				n_sel = R_W'(row_len(b));
			end
		end
	end

	// single position flip or uncorrectable flag
	always_comb begin
		cw_fix = pw;
		dec_flags = '0;
		if (syn != '0 && syn <= n_sel) begin
			dec_flags.corrected = 1'b1;
			for (int j = 1; j <= CW_W; j++) begin
				if (syn == R_W'(j)) begin
					cw_fix[j-1] = ~pw[j-1];
				end
			end
		end else if (syn > n_sel) begin
			dec_flags.uncorrectable = 1'b1;
		end
	end

	// gather data bits back in row order
	always_comb begin
		int idx;
		idx = 0;
		ext = '0;
		for (int b = 1; b <= MAX_ROW_BYTES; b++) begin
			if (nb == NB_W'(b)) begin
				for (int j = 1; j <= CW_W; j++) begin
					if (j <= row_len(b) && !is_pow2(j)) begin
						idx = 8 * b - 1 - data_index(j);
						if (idx >= 0) begin
							ext[idx] = cw_fix[j-1];
						end
					end
				end
			end
		end
	end

	// parity bits are the syndrome of the data positions
	always_comb begin
		enc = pw;
		for (int k = 0; k < R_W; k++) begin
			if ((1 << k) <= CW_W) begin
				enc[(1 << k) - 1] = syn[k];
			end
		end
	end

	// zero the fields of the other mode
	always_comb begin
		if (mode == MODE_DECODE) begin
			codeword_out = '0;
			data_out = ext;
			syndrome = syn;
			flags = dec_flags;
		end else begin
			codeword_out = enc;
			data_out = '0;
			syndrome = '0;
			flags = '0;
		end
	end

endmodule

>>> rtl/hamming_sec_row_codec.sv
// hamming single-error-correcting row codec, three-stage pipeline top level
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+----------------------------------------------
//  config   | cfg_we                         | cfg_wdata (bytes_per_row)
//  input    | in_valid / in_ready            | mode, data_in, codeword_in
//  output   | out_valid / out_ready          | codeword_out, data_out, syndrome, corrected,
//           |                                | uncorrectable
//
// one beat per cycle sustained while out_ready is high; an accepted beat passes through the
// stage one, stage two and stage three registers before out_valid rises
// stages: position scatter, syndrome xor trees, parity fill / correct and extract
// each stage advances when it is empty or the next one advances, so bubbles close up
// a stalled output holds the last stage; in_ready falls only once all three stages hold beats
// arst_n clears the valid bits and loads a row length of four bytes, or MAX_ROW_BYTES if smaller
module hamming_sec_row_codec #(
	parameter int MAX_ROW_BYTES = 4,
	localparam int DATA_W = 8 * MAX_ROW_BYTES,
	localparam int R_W = hsc_pkg::parity_count(DATA_W),
	localparam int CW_W = DATA_W + R_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  logic [DATA_W-1:0] data_in,
	input  logic [CW_W-1:0]   codeword_in,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [CW_W-1:0]   codeword_out,
	output logic [DATA_W-1:0] data_out,
	output logic [R_W-1:0]    syndrome,
	output logic              corrected,
	output logic              uncorrectable
);
	import hsc_pkg::*;

	localparam int NB_W = $clog2(MAX_ROW_BYTES + 1);
	localparam int NB_RESET = (MAX_ROW_BYTES < 4) ? MAX_ROW_BYTES : 4;

	logic [NB_W-1:0] nb_q;
	logic [NB_W-1:0] nb_next;

	logic            v_s1, v_s2, v_s3;
	logic            adv1, adv2, adv3;
	hsc_mode_t       mode_s1, mode_s2;
	logic [NB_W-1:0] nb_s1, nb_s2;
	logic [CW_W-1:0] pw_s1, pw_s2;
	logic [R_W-1:0]  syn_s2;

	logic [CW_W-1:0] pw_c;
	logic [R_W-1:0]  syn_c;
	logic [CW_W-1:0] cw_c;
	logic [DATA_W-1:0] data_c;
	logic [R_W-1:0]  syndrome_c;
	hsc_flags_t      flags_c;

	logic [CW_W-1:0]   codeword_s3;
	logic [DATA_W-1:0] data_s3;
	logic [R_W-1:0]    syndrome_s3;
	hsc_flags_t        flags_s3;

	// row length register, stored already clamped to 1..MAX_ROW_BYTES
	always_comb begin
		if (cfg_wdata == 3'd0) begin
			nb_next = NB_W'(1);
		end else if (int'(cfg_wdata) > MAX_ROW_BYTES) begin
			nb_next = NB_W'(MAX_ROW_BYTES);
		end else begin
			nb_next = NB_W'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q <= NB_W'(NB_RESET);
		end else if (cfg_we) begin
			nb_q <= nb_next;
		end
	end

	// stage advance chain
	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	// stage one: position word
	hsc_scatter #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_scatter (
		.mode        (hsc_mode_t'(mode)),
		.nb          (nb_q),
		.data_in     (data_in),
		.codeword_in (codeword_in),
		.pw          (pw_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			mode_s1 <= hsc_mode_t'(mode);
			nb_s1 <= nb_q;
			pw_s1 <= pw_c;
		end
	end

	// stage two: syndrome
	hsc_syndrome #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_syndrome (
		.pw  (pw_s1),
		.syn (syn_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			mode_s2 <= mode_s1;
			nb_s2 <= nb_s1;
			pw_s2 <= pw_s1;
			syn_s2 <= syn_c;
		end
	end

	// stage three: result register
	hsc_finish #(.MAX_ROW_BYTES(MAX_ROW_BYTES)) u_finish (
		.mode         (mode_s2),
		.nb           (nb_s2),
		.pw           (pw_s2),
		.syn          (syn_s2),
		.codeword_out (cw_c),
		.data_out     (data_c),
		.syndrome     (syndrome_c),
		.flags        (flags_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			codeword_s3 <= cw_c;
			data_s3 <= data_c;
			syndrome_s3 <= syndrome_c;
			flags_s3 <= flags_c;
		end
	end

	// output drive
	assign out_valid = v_s3;
	assign codeword_out = codeword_s3;
	assign data_out = data_s3;
	assign syndrome = syndrome_s3;
	assign corrected = flags_s3.corrected;
	assign uncorrectable = flags_s3.uncorrectable;

`ifndef SYNTHESIS
	// a full first stage that cannot move must block the input
	a_in_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !adv2) |-> !in_ready)
		else $error("input accepted while first stage is stalled");

	// a stalled middle beat is neither dropped nor replaced
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv3) |=> (v_s2 && $stable(syn_s2) && $stable(pw_s2)))
		else $error("middle stage changed while stalled");

	// the two flags never show together
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(corrected && uncorrectable))
		else $error("corrected and uncorrectable both set");

	// an encoded result carries no decode status
	a_encode_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && codeword_out != '0) |->
		(syndrome == '0 && data_out == '0 && !corrected && !uncorrectable))
		else $error("encode result with decode fields set");
`endif

endmodule
